>>> hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and codes for the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int FMT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int PIXEL_W    = 32;
  localparam int TIDX_W     = 12;
  localparam int TVAL_W     = 4;
  localparam int PAL_DEPTH  = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_FORMAT   = 2'd1;

  // format codes
  localparam logic [FMT_W-1:0] FMT_MONO     = 4'd0;
  localparam logic [FMT_W-1:0] FMT_GRAY4    = 4'd1;
  localparam logic [FMT_W-1:0] FMT_GRAY8    = 4'd2;
  localparam logic [FMT_W-1:0] FMT_RGB332   = 4'd3;
  localparam logic [FMT_W-1:0] FMT_RGB565   = 4'd4;
  localparam logic [FMT_W-1:0] FMT_RGB565BE = 4'd5;
  localparam logic [FMT_W-1:0] FMT_RGB888   = 4'd6;
  localparam logic [FMT_W-1:0] FMT_RGBA8888 = 4'd7;
  localparam logic [FMT_W-1:0] FMT_PALETTE  = 4'd8;
  localparam logic [FMT_W-1:0] FMT_ARGB4444 = 4'd9;
  localparam logic [FMT_W-1:0] FMT_BGRA     = 4'd11;

  localparam logic [FMT_W-1:0] FMT_RESET    = FMT_GRAY8;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  // conversion result classes
  localparam logic [1:0] CV_NONE = 2'd0;
  localparam logic [1:0] CV_WORD = 2'd1;
  localparam logic [1:0] CV_BIT  = 2'd2;
  localparam logic [1:0] CV_NIB  = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel;
    logic               end_of_run;
    logic [TIDX_W-1:0]  table_index;
    logic [TVAL_W-1:0]  table_value;
  } pix_t;

  typedef struct packed {
    logic [31:0] out_data;
    logic        out_last;
    logic        unsupported;
  } res_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [31:0] val;
  } conv_t;

endpackage

>>> hdl/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_converter
// Stream converter between pixel formats, with mono/nibble packing and an
// inverse palette table for palette-index output.
// ----------------------------------------------------------------------------
// the input and table read are registered into stage 1 at accept, and the
// result register loads when stage 1 advances, which waits on a stalled output
// throughput: one item per cycle unless the result is stalled; the inverse
// table port is used once per item; packed formats give one result per 8
// (mono) or 2 (nibble) pixels, or on end of run; table writes give no result
// reset: formats return to gray8, packer and pipeline empty; table not cleared
module pixel_format_converter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfc_pkg::FMT_W-1:0]     cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  pfc_pkg::pix_t                 pix,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pfc_pkg::res_t                 res
);

  localparam int PAL_AW = $clog2(pfc_pkg::PAL_DEPTH);

  logic [pfc_pkg::FMT_W-1:0] source_format, dest_format;

  logic                         pix_acc;
  logic [PAL_AW-1:0]            pal_addr;
  logic [pfc_pkg::TVAL_W-1:0]   pal_data;

  // stage 1
  logic                         s1_valid;
  logic                         s1_kind;
  logic                         s1_last;
  logic [pfc_pkg::PIXEL_W-1:0]  s1_pixel;
  logic                         s1_adv;

  pfc_pkg::conv_t conv;

  // packer
  logic [7:0] pack_acc, pack_acc_next;
  logic [2:0] pack_pos, pack_pos_next;
  logic [2:0] pos_m;
  logic [3:0] cnt;
  logic [3:0] full;
  logic [7:0] acc_or;
  logic       emit;
  pfc_pkg::res_t res_next;

  assign pix_acc   = pix_valid && pix_ready;
  assign s1_adv    = s1_valid && (!res_valid || res_ready);
  assign pix_ready = !s1_valid || s1_adv;

  // table writes use the item's index, pixels look up by r4 g4 b4
  assign pal_addr = (pix.kind == pfc_pkg::KIND_TABLE) ? pix.table_index[PAL_AW-1:0]
                  : {pix.pixel[7:4], pix.pixel[15:12], pix.pixel[23:20]};

  pfc_ram #(
    .WIDTH(pfc_pkg::TVAL_W),
    .DEPTH(pfc_pkg::PAL_DEPTH)
  ) u_pal (
    .clk  (clk),
    .we   (pix_acc && (pix.kind == pfc_pkg::KIND_TABLE)),
    .re   (pix_acc && (pix.kind == pfc_pkg::KIND_PIXEL)),
    .addr (pal_addr),
    .wdata(pix.table_value),
    .rdata(pal_data)
  );

  pfc_convert u_conv (
    .source_format(source_format),
    .dest_format  (dest_format),
    .pixel        (s1_pixel),
    .pal_data     (pal_data),
    .conv         (conv)
  );

  always_comb begin
    pos_m  = (conv.cls == pfc_pkg::CV_BIT) ? pack_pos : {2'b00, pack_pos[0]};
    full   = (conv.cls == pfc_pkg::CV_BIT) ? 4'd8 : 4'd2;
    if (conv.cls == pfc_pkg::CV_BIT) begin
      acc_or = conv.val[0] ? (8'h80 >> pos_m) : 8'h00;
    end else begin
      acc_or = pos_m[0] ? {4'h0, conv.val[3:0]} : {conv.val[3:0], 4'h0};
    end
    cnt = {1'b0, pos_m} + 4'd1;

    pack_acc_next     = pack_acc;
    pack_pos_next     = pack_pos;
    emit              = 1'b0;
    res_next.out_data = '0;
    res_next.out_last = s1_last;
    res_next.unsupported = 1'b0;

    if (s1_kind == pfc_pkg::KIND_PIXEL) begin
      case (conv.cls)
        pfc_pkg::CV_NONE: begin
          emit = 1'b1;
          res_next.unsupported = 1'b1;
        end
        pfc_pkg::CV_WORD: begin
          emit = 1'b1;
          res_next.out_data = conv.val;
        end
        default: begin
          if (cnt >= full || s1_last) begin
            emit = 1'b1;
            res_next.out_data = {24'd0, pack_acc | acc_or};
            pack_acc_next = '0;
            pack_pos_next = '0;
          end else begin
            pack_acc_next = pack_acc | acc_or;
            pack_pos_next = cnt[2:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= pfc_pkg::FMT_RESET;
      dest_format   <= pfc_pkg::FMT_RESET;
      pack_acc      <= '0;
      pack_pos      <= '0;
      s1_valid      <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == pfc_pkg::REG_SOURCE_FORMAT ||
                        cfg_index == pfc_pkg::REG_DEST_FORMAT)) begin
        if (cfg_index == pfc_pkg::REG_SOURCE_FORMAT) begin
          source_format <= cfg_data;
        end else begin
          dest_format <= cfg_data;
        end
        pack_acc <= '0;
        pack_pos <= '0;
      end else if (s1_adv) begin
        pack_acc <= pack_acc_next;
        pack_pos <= pack_pos_next;
      end

      if (pix_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_kind  <= pix.kind;
      s1_last  <= pix.end_of_run;
      s1_pixel <= pix.pixel;
    end
    if (s1_adv && emit) begin
      res <= res_next;
    end
  end

endmodule

>>> hdl/pfc_ram.sv
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/pfc_convert.sv
// ----------------------------------------------------------------------------
// pfc_convert
// Combinational conversion of one pixel between the configured formats.
// ----------------------------------------------------------------------------
module pfc_convert (
  input  logic [pfc_pkg::FMT_W-1:0]   source_format,
  input  logic [pfc_pkg::FMT_W-1:0]   dest_format,
  input  logic [pfc_pkg::PIXEL_W-1:0] pixel,
  input  logic [pfc_pkg::TVAL_W-1:0]  pal_data,
  output pfc_pkg::conv_t              conv
);

  function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [10:0] s;
    s = {2'b00, r, 1'b0} + {3'b000, r} + {1'b0, g, 2'b00} + {3'b000, b};
    return s[10:3];
  endfunction

  logic [7:0]  r8, g8, b8, a8;
  logic [15:0] q16;
  logic [7:0]  q8;
  logic [3:0]  q4;
  logic [4:0]  y5;
  logic [7:0]  y_rgb, y_565;

  assign r8  = pixel[7:0];
  assign g8  = pixel[15:8];
  assign b8  = pixel[23:16];
  assign a8  = pixel[31:24];
  assign q16 = pixel[15:0];
  assign q8  = pixel[7:0];
  assign q4  = pixel[3:0];
  assign y5  = {q4, q4[3]};

  assign y_rgb = gray_of(r8, g8, b8);
  // expand 565 channels to 8 bits before the gray sum
  assign y_565 = gray_of({q16[15:11], q16[15:13]}, {q16[10:5], q16[10:9]},
                         {q16[4:0], q16[4:2]});

  always_comb begin
    conv.cls = pfc_pkg::CV_NONE;
    conv.val = '0;
    case (source_format) inside
      pfc_pkg::FMT_GRAY4: begin
        case (dest_format)
          pfc_pkg::FMT_GRAY4: begin
            conv.cls = pfc_pkg::CV_NIB;
            conv.val = {28'd0, q4};
          end
          pfc_pkg::FMT_GRAY8: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {24'd0, q4, q4};
          end
          pfc_pkg::FMT_RGB332: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {24'd0, q4[3:1], q4[3:1], q4[3:2]};
          end
          pfc_pkg::FMT_RGB565: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {16'd0, y5, y5, 1'b0, y5};
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_GRAY8: begin
        case (dest_format)
          pfc_pkg::FMT_MONO: begin
            conv.cls = pfc_pkg::CV_BIT;
            conv.val = {31'd0, ~q8[7]};
          end
          pfc_pkg::FMT_GRAY4: begin
            conv.cls = pfc_pkg::CV_NIB;
            conv.val = {28'd0, q8[7:4]};
          end
          pfc_pkg::FMT_GRAY8: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {24'd0, q8};
          end
          pfc_pkg::FMT_RGB332: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {24'd0, q8[7:5], q8[7:5], q8[7:6]};
          end
          pfc_pkg::FMT_RGB565: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {16'd0, q8[7:3], q8[7:2], q8[7:3]};
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_RGB565: begin
        case (dest_format)
          pfc_pkg::FMT_MONO: begin
            // dark when the top bit of every channel is clear
            conv.cls = pfc_pkg::CV_BIT;
            conv.val = {31'd0, ~(q16[15] | q16[10] | q16[4])};
          end
          pfc_pkg::FMT_GRAY8: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {24'd0, y_565};
          end
          pfc_pkg::FMT_RGB565: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {16'd0, q16};
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_RGB888, pfc_pkg::FMT_RGBA8888: begin
        case (dest_format)
          pfc_pkg::FMT_MONO: begin
            conv.cls = pfc_pkg::CV_BIT;
            conv.val = {31'd0, ~y_rgb[7]};
          end
          pfc_pkg::FMT_GRAY4: begin
            conv.cls = pfc_pkg::CV_NIB;
            conv.val = {28'd0, y_rgb[7:4]};
          end
          pfc_pkg::FMT_GRAY8: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {24'd0, y_rgb};
          end
          pfc_pkg::FMT_RGB332: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {24'd0, r8[7:5], g8[7:5], b8[7:6]};
          end
          pfc_pkg::FMT_RGB565: begin
            conv.cls = pfc_pkg::CV_WORD;
            conv.val = {16'd0, r8[7:3], g8[7:2], b8[7:3]};
          end
          pfc_pkg::FMT_PALETTE: begin
            conv.cls = pfc_pkg::CV_NIB;
            conv.val = {28'd0, pal_data};
          end
          pfc_pkg::FMT_ARGB4444: begin
            if (source_format == pfc_pkg::FMT_RGBA8888) begin
              conv.cls = pfc_pkg::CV_WORD;
              conv.val = {16'd0, a8[7:4], r8[7:4], g8[7:4], b8[7:4]};
            end
          end
          pfc_pkg::FMT_BGRA: begin
            if (source_format == pfc_pkg::FMT_RGBA8888) begin
              conv.cls = pfc_pkg::CV_WORD;
              conv.val = {a8, r8, g8, b8};
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks for the pixel format converter, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker (
  input logic          clk,
  input logic          rst,
  input logic          pix_ready,
  input logic          res_valid,
  input logic          res_ready,
  input pfc_pkg::res_t res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // unsupported pairs carry zero data
  a_unsup_zero: assert property (@(posedge clk)
    res_valid && res.unsupported |-> res.out_data == 32'd0)
    else $error("unsupported result with nonzero data");

  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> pix_ready)
    else $error("input not ready right after reset");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
  .clk      (clk),
  .rst      (rst),
  .pix_ready(pix_ready),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res      (res)
);
